[rtl/sphere_frustum_cull_unit_assert.svh]
// Assertion macros for the sphere frustum cull unit.
`ifndef SPHERE_FRUSTUM_CULL_UNIT_ASSERT_SVH
`define SPHERE_FRUSTUM_CULL_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SFC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SFC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/sfc_pkg.sv]
// Package: types and constants of the sphere frustum cull unit.
package sfc_pkg;
  localparam int DefPlaneCount = 6;
  localparam int DefFracBits   = 16;
  localparam int MaxPlanes     = 6;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_BUILD = 2'd1;
  localparam logic [1:0] FUNC_TEST  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        sphere_radius;
  } sfc_in_t;

  typedef struct packed {
    logic inside_res;
    logic degenerate;
  } sfc_out_t;

  // Divider handshake
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } sfc_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } sfc_div_rsp_t;

  // matrix row combined with row 3 for each plane
  function automatic logic [1:0] plane_row(input logic [2:0] p);
    unique case (p)
      3'd0, 3'd1: plane_row = 2'd2;
      3'd2, 3'd3: plane_row = 2'd0;
      default:    plane_row = 2'd1;
    endcase
  endfunction

  function automatic logic plane_sub(input logic [2:0] p);
    plane_sub = p[0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -65'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction
endpackage

[rtl/sfc_divider.sv]
// Iterative unsigned 64-bit divider, restoring, one quotient bit per cycle.
module sfc_divider import sfc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  sfc_div_req_t req,
  output sfc_div_rsp_t rsp
);
  logic [63:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 64'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) dvs_r <= req.divisor;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

[rtl/sphere_frustum_cull_unit.sv]
// Sphere frustum cull unit: 4x4 matrix load, plane build, sphere test.
// Load: writes one matrix element, no result. One request at a time; in_ready stays low
//   until the result is taken. Test: per plane, multiply-accumulate steps then a compare
//   on one shared 32x32 multiplier; the result follows the first rejecting or last plane.
// Build: per plane extract, sum of squares, root, then a divide of each of the four
//   components on the bit-serial 64-bit divider (skipped for a zero-length normal).
// Synchronous active-low reset clears control, planes and the degenerate flag.
module sphere_frustum_cull_unit import sfc_pkg::*; #(
  parameter int PLANE_COUNT = DefPlaneCount,
  parameter int FRAC_BITS   = DefFracBits
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sfc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output sfc_out_t out_data
);
  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_EXT   = 9'b000000010,  // extract: read row 3, read other row, combine, per component
    ST_SQ    = 9'b000000100,  // sum of squares, one term per cycle
    ST_SQRT  = 9'b000001000,  // digit-by-digit root, two bits per cycle
    ST_DIV   = 9'b000010000,  // launch divide for one component
    ST_DWAIT = 9'b000100000,
    ST_PNEXT = 9'b001000000,  // build: next plane or result
    ST_MAC   = 9'b010000000,  // test: one product per cycle
    ST_CMP   = 9'b100000000
  } state_t;

  localparam int PIdxW = 3;
  localparam logic [PIdxW-1:0] LastPlane = PIdxW'(PLANE_COUNT - 1);
  localparam int PlaneEntries = MaxPlanes * 4;

  state_t state_r, state_nxt;

  // matrix memory, written at load, read through one registered port in build
  logic signed [31:0] mat_mem [16];
  logic signed [31:0] mat_rd_r;
  // plane registers: 24 entries, reset to zero
  logic signed [31:0] plane_r [PlaneEntries];
  logic               degen_r;

  logic [PIdxW-1:0]   p_r;
  logic [1:0]         k_r;
  logic [1:0]         sub_r;   // step within extract: read row 3, read other, combine
  logic signed [31:0] comp_r [4];
  logic [63:0]        sum_r;
  logic [63:0]        sq_v_r, sq_res_r, sq_bit_r;

  logic signed [31:0] cx_r, cy_r, cz_r;
  logic signed [63:0] limit_r;
  logic signed [63:0] acc_r, prod_r;
  logic               prod_v_r;
  sfc_out_t           out_r;
  logic               out_valid_r;

  sfc_div_req_t div_req;
  sfc_div_rsp_t div_rsp;

  logic       accept;
  logic       load_we;
  logic       last_p;
  logic       rej_now;
  logic       out_set;
  logic [3:0] rd_addr;

  sfc_divider u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign accept    = in_valid && in_ready;
  assign load_we   = accept && (in_data.func == FUNC_LOAD);
  assign last_p    = (p_r == LastPlane);

  // Shared multiplier: squares in build, plane products in test
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  always_comb begin
    mul_a = comp_r[k_r];
    mul_b = comp_r[k_r];
    if (state_r == ST_MAC) begin
      mul_a = plane_r[{p_r, k_r}];
      unique case (k_r)
        2'd0: mul_b = cx_r;
        2'd1: mul_b = cy_r;
        2'd2: mul_b = cz_r;
        default: mul_b = 32'sd1 <<< FRAC_BITS;
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // saturating 64-bit add
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63])
      sat_add = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else
      sat_add = s;
  endfunction

  logic [63:0] sq_trial;
  assign sq_trial = sq_res_r + sq_bit_r;

  // divider operands for the current component
  logic signed [31:0] comp_sel;
  logic               cneg;
  logic [63:0]        cmag;
  assign comp_sel = comp_r[k_r];
  assign cneg     = comp_sel[31];
  assign cmag     = cneg ? 64'(-65'(comp_sel)) : {32'd0, comp_sel};
  always_comb begin
    div_req.start    = (state_r == ST_DIV);
    div_req.dividend = cmag << FRAC_BITS;
    div_req.divisor  = sq_res_r;
  end

  logic signed [31:0] qsat;
  always_comb begin
    if (cneg) begin
      if (div_rsp.quotient > 64'h80000000) qsat = 32'sh80000000;
      else qsat = 32'(-div_rsp.quotient);
    end else begin
      if (div_rsp.quotient > 64'h7fffffff) qsat = 32'sh7fffffff;
      else qsat = div_rsp.quotient[31:0];
    end
  end

  // reject once the distance is at or below minus the scaled radius
  assign rej_now = (acc_r <= limit_r);
  assign out_set = ((state_r == ST_PNEXT) && last_p) ||
                   ((state_r == ST_CMP) && (rej_now || last_p));

  assign rd_addr = (sub_r == 2'd0) ? {k_r, 2'd3} : {k_r, plane_row(p_r)};

  always_ff @(posedge clk) begin
    if (load_we) mat_mem[in_data.element_index] <= in_data.element_value;
    mat_rd_r <= mat_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        unique case (in_data.func)
          FUNC_BUILD: state_nxt = ST_EXT;
          FUNC_TEST:  state_nxt = ST_MAC;
          default:    state_nxt = ST_IDLE;
        endcase
      end
      ST_EXT:   if (sub_r == 2'd2 && k_r == 2'd3) state_nxt = ST_SQ;
      ST_SQ:    if (k_r == 2'd2) state_nxt = ST_SQRT;
      ST_SQRT:  if (sq_bit_r == 64'd0) state_nxt = (sq_res_r == 64'd0) ? ST_PNEXT : ST_DIV;
      ST_DIV:   state_nxt = ST_DWAIT;
      ST_DWAIT: if (div_rsp.done) state_nxt = (k_r == 2'd3) ? ST_PNEXT : ST_DIV;
      ST_PNEXT: state_nxt = last_p ? ST_IDLE : ST_EXT;
      ST_MAC:   if (prod_v_r && k_r == 2'd0) state_nxt = ST_CMP;
      ST_CMP:   state_nxt = (rej_now || last_p) ? ST_IDLE : ST_MAC;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_r       <= '0;
      degen_r     <= 1'b0;
      for (int i = 0; i < PlaneEntries; i++) plane_r[i] <= '0;
      for (int i = 0; i < 4; i++) comp_r[i] <= '0;
      p_r <= '0; k_r <= '0; sub_r <= '0; prod_v_r <= 1'b0;
      sum_r <= '0; sq_v_r <= '0; sq_res_r <= '0; sq_bit_r <= '0;
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
      limit_r <= '0; acc_r <= '0; prod_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_set) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (accept) begin
          p_r <= '0; k_r <= '0; sub_r <= '0; prod_v_r <= 1'b0;
          cx_r <= in_data.center_x;
          cy_r <= in_data.center_y;
          cz_r <= in_data.center_z;
          limit_r <= -$signed(64'(in_data.sphere_radius) << FRAC_BITS);
          acc_r <= '0;
          if (in_data.func == FUNC_BUILD) degen_r <= 1'b0;
        end
        ST_EXT: begin
          unique case (sub_r)
            2'd0: sub_r <= 2'd1;
            2'd1: begin
              comp_r[k_r] <= mat_rd_r;
              sub_r <= 2'd2;
            end
            default: begin
              comp_r[k_r] <= sat32(plane_sub(p_r)
                ? 65'(comp_r[k_r]) - 65'(mat_rd_r) : 65'(comp_r[k_r]) + 65'(mat_rd_r));
              sub_r <= 2'd0;
              k_r <= k_r + 2'd1;
              if (k_r == 2'd3) sum_r <= '0;
            end
          endcase
        end
        ST_SQ: begin
          sum_r <= sum_r + $unsigned(mul_p);
          k_r <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
          if (k_r == 2'd2) begin
            sq_v_r   <= sum_r + $unsigned(mul_p);
            sq_res_r <= '0;
            sq_bit_r <= 64'd1 << 62;
          end
        end
        ST_SQRT: begin
          if (sq_bit_r != 64'd0) begin
            if (sq_v_r >= sq_trial) begin
              sq_v_r   <= sq_v_r - sq_trial;
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_bit_r <= sq_bit_r >> 2;
          end else if (sq_res_r == 64'd0) begin
            // zero-length normal: keep the plane as extracted
            degen_r <= 1'b1;
            for (int j = 0; j < 4; j++) plane_r[{p_r, 2'(j)}] <= comp_r[j];
          end
        end
        ST_DIV: ;
        ST_DWAIT: if (div_rsp.done) begin
          plane_r[{p_r, k_r}] <= qsat;
          k_r <= k_r + 2'd1;
        end
        ST_PNEXT: begin
          p_r <= p_r + 3'd1;
          k_r <= '0;
          sub_r <= '0;
          if (last_p) begin
            out_r.inside_res <= 1'b0;
            out_r.degenerate <= degen_r;
          end
        end
        ST_MAC: begin
          // product registered, accumulated in the next cycle
          prod_r <= mul_p;
          k_r <= k_r + 2'd1;
          if (prod_v_r) acc_r <= sat_add(acc_r, prod_r);
          prod_v_r <= !(prod_v_r && k_r == 2'd0);
        end
        ST_CMP: begin
          p_r <= p_r + 3'd1;
          k_r <= '0;
          acc_r <= '0;
          if (rej_now || last_p) begin
            out_r.inside_res <= !rej_now;
            out_r.degenerate <= degen_r;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/sfc_checker.sv]
// Port-level checker for the sphere frustum cull unit, with its bind.
`include "sphere_frustum_cull_unit_assert.svh"
module sfc_checker import sfc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input sfc_out_t out_data
);
  `SFC_ASSERT_IMP(a_busy_when_out, out_valid, !in_ready)
  `SFC_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid && $stable(out_data))
  `SFC_ASSERT_NXT(a_accept_blocks, in_valid && in_ready, !out_valid)
endmodule

bind sphere_frustum_cull_unit sfc_checker u_sfc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
